[src/hsfd_pkg.sv]
// Constants and helper functions for the humidity sensor frame decoder.
// No dependencies; compiled first.
`default_nettype none

package hsfd_pkg;

	localparam logic [7:0] CrcInit = 8'hFF;
	localparam logic [7:0] CrcPoly = 8'h31;

	localparam logic [14:0] TempSpan   = 15'd17500;
	localparam logic [13:0] HumSpan    = 14'd10000;
	localparam logic [14:0] TempOffset = 15'd4500;

	localparam int ProdWidth = 31;

	// One byte through the CRC-8, most significant bit first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Floor of x / 65535 for x below 2^31: x = hi * 65535 + (lo + hi), and
	// lo + hi stays below twice the divisor, so one compare corrects it.
	function automatic logic [14:0] div_65535(input logic [ProdWidth-1:0] x);
		logic [14:0] hi;
		logic [16:0] rem;
		hi  = x[30:16];
		rem = {1'b0, x[15:0]} + {2'b00, hi};
		return hi + {14'd0, (rem >= 17'd65535)};
	endfunction

endpackage

`default_nettype wire

[src/hsfd_if.sv]
// Handshake channels of the humidity sensor frame decoder.
// Depends on nothing; compiled after hsfd_pkg.
`default_nettype none

interface hsfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface hsfd_result_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] temperature_centi;
	logic        [13:0] humidity_centi;
	logic        [15:0] raw_temperature;
	logic        [15:0] raw_humidity;
	logic               crc_mismatch;

	modport source (output valid, output temperature_centi, output humidity_centi,
		output raw_temperature, output raw_humidity, output crc_mismatch, input ready);
	modport sink   (input valid, input temperature_centi, input humidity_centi,
		input raw_temperature, input raw_humidity, input crc_mismatch, output ready);
endinterface

`default_nettype wire

[src/humidity_sensor_frame_decoder.sv]
// Top level of the humidity sensor frame decoder: frame assembly, CRC check
// and conversion. Depends on hsfd_pkg and the channels in hsfd_if.
//
//   channel  | role   | request carries
//   ---------+--------+------------------------------------------------
//   rx       | sink   | one frame byte and its start-of-frame mark
//   result   | source | converted and raw words plus checksum error flag
//
// A request is taken in every cycle when the pipeline is not full.
// After its sixth byte the frame result passes through the frame register,
// multiplier register, then division correction into the output register.
// Reset clears frame position, CRC, error flag and all valid bits.
// A stalled result holds the output; earlier stages keep filling until all
// three are occupied, and only then does rx.ready drop.
`default_nettype none

module humidity_sensor_frame_decoder (
	input  logic               clk,
	input  logic               arst_n,
	hsfd_rx_if.sink            rx,
	hsfd_result_if.source      result
);

	localparam logic [2:0] PosTempHi  = 3'd0;
	localparam logic [2:0] PosTempLo  = 3'd1;
	localparam logic [2:0] PosTempCrc = 3'd2;
	localparam logic [2:0] PosHumHi   = 3'd3;
	localparam logic [2:0] PosHumLo   = 3'd4;
	localparam logic [2:0] PosHumCrc  = 3'd5;

	logic [2:0]  byte_pos_q;
	logic [7:0]  crc_q;
	logic [31:0] word_q;
	logic        err_q;

	logic        rx_fire;
	logic [2:0]  pos;
	logic [7:0]  crc_nxt;
	logic        crc_bad;
	logic        frame_done;

	logic        s1_valid_q;
	logic [15:0] rt_s1;
	logic [15:0] rh_s1;
	logic        err_s1;

	logic                           s2_valid_q;
	logic [hsfd_pkg::ProdWidth-1:0] tprod_s2;
	logic [hsfd_pkg::ProdWidth-1:0] hprod_s2;
	logic [15:0]                    rt_s2;
	logic [15:0]                    rh_s2;
	logic                           err_s2;

	logic               out_valid_q;
	logic signed [14:0] temp_q;
	logic [13:0]        hum_q;
	logic [15:0]        rt_q;
	logic [15:0]        rh_q;
	logic               err_out_q;

	logic        out_adv;
	logic        s2_take;
	logic        s1_take;
	logic [14:0] tq;
	logic [14:0] hq;

	assign out_adv = !out_valid_q || result.ready;
	assign s2_take = !s2_valid_q || out_adv;
	assign s1_take = !s1_valid_q || s2_take;

	assign rx.ready = s1_take;
	assign rx_fire  = rx.valid && s1_take;

	assign pos = (rx.frame_start || byte_pos_q > PosHumCrc) ? PosTempHi : byte_pos_q;
	assign crc_nxt = hsfd_pkg::crc8_byte((pos == PosTempHi) ? hsfd_pkg::CrcInit : crc_q,
		rx.rx_byte);
	assign crc_bad = crc_q != rx.rx_byte;
	assign frame_done = rx_fire && pos == PosHumCrc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= PosTempHi;
			crc_q      <= hsfd_pkg::CrcInit;
			word_q     <= '0;
			err_q      <= 1'b0;
		end else if (rx_fire) begin
			byte_pos_q <= (pos == PosHumCrc) ? PosTempHi : pos + 3'd1;
			case (pos)
				PosTempHi: begin
					err_q         <= 1'b0;
					crc_q         <= crc_nxt;
					word_q[31:24] <= rx.rx_byte;
				end
				PosTempLo: begin
					crc_q         <= crc_nxt;
					word_q[23:16] <= rx.rx_byte;
				end
				PosHumHi: begin
					crc_q         <= crc_nxt;
					word_q[15:8]  <= rx.rx_byte;
				end
				PosHumLo: begin
					crc_q         <= crc_nxt;
					word_q[7:0]   <= rx.rx_byte;
				end
				default: begin
					err_q <= err_q | crc_bad;
					crc_q <= hsfd_pkg::CrcInit;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_take) begin
				s1_valid_q <= frame_done;
			end
			if (s2_take) begin
				s2_valid_q <= s1_valid_q;
			end
			if (out_adv) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_done) begin
			rt_s1  <= word_q[31:16];
			rh_s1  <= word_q[15:0];
			err_s1 <= err_q | crc_bad;
		end
		if (s2_take && s1_valid_q) begin
			tprod_s2 <= hsfd_pkg::ProdWidth'(rt_s1) * hsfd_pkg::ProdWidth'(hsfd_pkg::TempSpan);
			hprod_s2 <= hsfd_pkg::ProdWidth'(rh_s1) * hsfd_pkg::ProdWidth'(hsfd_pkg::HumSpan);
			rt_s2    <= rt_s1;
			rh_s2    <= rh_s1;
			err_s2   <= err_s1;
		end
		if (out_adv && s2_valid_q) begin
			temp_q    <= err_s2 ? 15'sd0 : signed'(tq - hsfd_pkg::TempOffset);
			hum_q     <= err_s2 ? 14'd0 : hq[13:0];
			rt_q      <= rt_s2;
			rh_q      <= rh_s2;
			err_out_q <= err_s2;
		end
	end

	assign tq = hsfd_pkg::div_65535(tprod_s2);
	assign hq = hsfd_pkg::div_65535(hprod_s2);

	assign result.valid             = out_valid_q;
	assign result.temperature_centi = temp_q;
	assign result.humidity_centi    = hum_q;
	assign result.raw_temperature   = rt_q;
	assign result.raw_humidity      = rh_q;
	assign result.crc_mismatch      = err_out_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= PosHumCrc)
		else $error("frame position out of range");

	a_crc_at_word_start: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_pos_q == PosTempHi || byte_pos_q == PosHumHi) |-> crc_q == hsfd_pkg::CrcInit)
		else $error("CRC not at its initial value at a word start");

	a_frame_enters: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> s1_valid_q)
		else $error("completed frame did not enter the pipeline");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_out_q) |-> (temp_q == 15'sd0 && hum_q == 14'd0))
		else $error("converted values not zero on checksum error");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> hum_q <= hsfd_pkg::HumSpan)
		else $error("humidity above full scale");

endmodule

`default_nettype wire

[test/humidity_sensor_frame_decoder_tb.sv]
// Self-checking testbench for humidity_sensor_frame_decoder: drives frame bytes, predicts
// every decoded reading in its own model and compares each result field by field.
// Depends on hsfd_pkg, the channel interfaces in hsfd_if and the decoder RTL.
`timescale 1ns / 100ps
`default_nettype none

module humidity_sensor_frame_decoder_tb;

	localparam logic [7:0] CrcSeed = 8'hFF;
	localparam logic [7:0] CrcPolyLow = 8'h31;
	localparam int RandomBytes = 1250;
	localparam int StallLimit = 4000;
	localparam int TailCycles = 10;

	typedef enum int {SteadyFlow, SenderIdle, ReceiverStall, BothIdle} flow_mode_e;

	typedef struct {
		logic [7:0]  data;
		logic        start;
		int unsigned idle_pct;
		int unsigned stall_pct;
		bit          drain;
	} rx_request_t;

	typedef struct {
		logic signed [14:0] temperature_centi;
		logic        [13:0] humidity_centi;
		logic        [15:0] raw_temperature;
		logic        [15:0] raw_humidity;
		logic               crc_mismatch;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n;

	hsfd_rx_if     rx_ch ();
	hsfd_result_if res_ch ();

	humidity_sensor_frame_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch.sink),
		.result (res_ch.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	rx_request_t byte_queue[$];
	reading_t    reading_queue[$];

	int unsigned frame_pos;
	logic [7:0]  crc_acc;
	logic [31:0] frame_words;
	logic        crc_bad;

	int unsigned send_idle_pct;
	int unsigned send_stall_pct;
	int unsigned recv_stall_pct;
	bit          drain_next;
	int          queued_total;
	int          failures;
	int          quiet_cycles;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CrcPolyLow) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic start);
		reading_t    r;
		int unsigned tq;
		if (start || frame_pos >= 6) begin
			frame_pos = 0;
		end
		case (frame_pos)
			0: begin
				crc_bad = 1'b0;
				crc_acc = crc8_step(CrcSeed, b);
				frame_words[31:24] = b;
			end
			1: begin
				crc_acc = crc8_step(crc_acc, b);
				frame_words[23:16] = b;
			end
			3: begin
				crc_acc = crc8_step(crc_acc, b);
				frame_words[15:8] = b;
			end
			4: begin
				crc_acc = crc8_step(crc_acc, b);
				frame_words[7:0] = b;
			end
			default: begin
				if (crc_acc != b) begin
					crc_bad = 1'b1;
				end
				crc_acc = CrcSeed;
			end
		endcase
		if (frame_pos == 5) begin
			r.raw_temperature = frame_words[31:16];
			r.raw_humidity = frame_words[15:0];
			r.crc_mismatch = crc_bad;
			r.temperature_centi = '0;
			r.humidity_centi = '0;
			if (!crc_bad) begin
				tq = (32'd17500 * r.raw_temperature) / 32'd65535;
				r.temperature_centi = 15'(tq - 32'd4500);
				r.humidity_centi = 14'((32'd10000 * r.raw_humidity) / 32'd65535);
			end
			reading_queue.push_back(r);
			frame_pos = 0;
		end else begin
			frame_pos++;
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic start);
		rx_request_t q;
		q.data = b;
		q.start = start;
		q.idle_pct = send_idle_pct;
		q.stall_pct = send_stall_pct;
		q.drain = drain_next;
		drain_next = 1'b0;
		byte_queue.push_back(q);
		queued_total++;
	endtask

	task automatic queue_frame(input logic [15:0] rt, input logic [15:0] rh, input bit mark,
		input logic [7:0] t_flip, input logic [7:0] h_flip, input int nbytes);
		logic [7:0] bytes[6];
		bytes[0] = rt[15:8];
		bytes[1] = rt[7:0];
		bytes[2] = crc8_step(crc8_step(CrcSeed, rt[15:8]), rt[7:0]) ^ t_flip;
		bytes[3] = rh[15:8];
		bytes[4] = rh[7:0];
		bytes[5] = crc8_step(crc8_step(CrcSeed, rh[15:8]), rh[7:0]) ^ h_flip;
		for (int i = 0; i < nbytes; i++) begin
			queue_byte(bytes[i], (i == 0) ? mark : 1'b0);
		end
	endtask

	task automatic enter_mode(input flow_mode_e m);
		case (m)
			SteadyFlow: begin
				send_idle_pct = 0;
				send_stall_pct = 0;
			end
			SenderIdle: begin
				send_idle_pct = 54;
				send_stall_pct = 0;
			end
			ReceiverStall: begin
				send_idle_pct = 0;
				send_stall_pct = 54;
			end
			default: begin
				send_idle_pct = 19;
				send_stall_pct = 19;
			end
		endcase
		drain_next = 1'b1;
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(255));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_flip();
		return ($urandom_range(9) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
	endfunction

	// Sender side: presents queued bytes and feeds every accepted byte to the predictor.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready) begin
				decode_byte(rx_ch.rx_byte, rx_ch.frame_start);
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (byte_queue.size() != 0 && !(byte_queue[0].drain && reading_queue.size() != 0)
					&& $urandom_range(99) >= byte_queue[0].idle_pct) begin
					rx_ch.valid <= 1'b1;
					rx_ch.rx_byte <= byte_queue[0].data;
					rx_ch.frame_start <= byte_queue[0].start;
					recv_stall_pct <= byte_queue[0].stall_pct;
					void'(byte_queue.pop_front());
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	reading_t want;

	// Result side: random back-pressure and in-order comparison with predicted readings.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (reading_queue.size() == 0) begin
					$error("result arrived with no completed frame pending");
					failures++;
				end else begin
					want = reading_queue.pop_front();
					if (res_ch.temperature_centi !== want.temperature_centi) begin
						$error("temperature_centi expected %0d got %0d",
							want.temperature_centi, res_ch.temperature_centi);
						failures++;
					end
					if (res_ch.humidity_centi !== want.humidity_centi) begin
						$error("humidity_centi expected %0d got %0d",
							want.humidity_centi, res_ch.humidity_centi);
						failures++;
					end
					if (res_ch.raw_temperature !== want.raw_temperature) begin
						$error("raw_temperature expected %h got %h",
							want.raw_temperature, res_ch.raw_temperature);
						failures++;
					end
					if (res_ch.raw_humidity !== want.raw_humidity) begin
						$error("raw_humidity expected %h got %h",
							want.raw_humidity, res_ch.raw_humidity);
						failures++;
					end
					if (res_ch.crc_mismatch !== want.crc_mismatch) begin
						$error("crc_mismatch expected %b got %b",
							want.crc_mismatch, res_ch.crc_mismatch);
						failures++;
					end
				end
			end
			res_ch.ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= StallLimit) begin
				$display("humidity_sensor_frame_decoder regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int         kind;
		bit         resync;
		int         directed_total;
		flow_mode_e mode;

		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		rx_ch.frame_start = 1'b0;
		res_ch.ready = 1'b0;
		frame_pos = 0;
		crc_acc = CrcSeed;
		frame_words = '0;
		crc_bad = 1'b0;
		recv_stall_pct = 0;
		queued_total = 0;
		failures = 0;
		quiet_cycles = 0;

		enter_mode(SteadyFlow);
		queue_frame(16'h0000, 16'h0000, 1'b1, 8'h00, 8'h00, 6);
		queue_frame(16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 8'h00, 6);
		queue_frame(16'hA55A, 16'h5AA5, 1'b1, 8'h00, 8'h00, 2);
		queue_frame(16'h8000, 16'h7FFF, 1'b1, 8'h00, 8'h01, 6);
		queue_frame(16'h0001, 16'hFFFE, 1'b0, 8'hFF, 8'h00, 6);
		directed_total = queued_total;

		mode = BothIdle;
		resync = 1'b1;
		while (queued_total - directed_total < RandomBytes) begin
			if (flow_mode_e'(((queued_total - directed_total) * 8 / RandomBytes) % 4) != mode) begin
				mode = flow_mode_e'(((queued_total - directed_total) * 8 / RandomBytes) % 4);
				enter_mode(mode);
			end
			kind = $urandom_range(99);
			if (kind < 72) begin
				queue_frame(pick_word(), pick_word(), resync | $urandom_range(1),
					pick_flip(), pick_flip(), 6);
				resync = 1'b0;
			end else if (kind < 88) begin
				queue_frame(pick_word(), pick_word(), 1'b1, 8'h00, 8'h00, $urandom_range(5, 1));
				resync = 1'b1;
			end else begin
				repeat ($urandom_range(8, 1)) begin
					queue_byte(8'($urandom), $urandom_range(3) == 0);
				end
				resync = 1'b1;
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_queue.size() != 0 || rx_ch.valid || reading_queue.size() != 0) begin
			@(negedge clk);
		end
		repeat (TailCycles) @(negedge clk);

		if (failures == 0) begin
			$display("humidity_sensor_frame_decoder regression: pass");
		end else begin
			$display("humidity_sensor_frame_decoder regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
